// ===== rtl/vr_pkg.sv =====
// Shared widths and constants for the vector refraction pipeline.
// No dependencies; vr_sqrt and vector_refract use it by scoped names.
`default_nettype none

package vr_pkg;

  // Fixed-point format of all inputs and outputs
  localparam int FRAC_BITS = 14;
  localparam int IN_W      = 16;
  localparam int OUT_W     = 20;

  // Intermediate widths, sized to the value ranges of 16-bit operands
  localparam int EI_W   = 2 * IN_W + 1;          // eta * incident component
  localparam int DOT_W  = 2 * IN_W + 1;          // sum of three products
  localparam int COSI_W = DOT_W - FRAC_BITS;     // cosi
  localparam int E2_W   = 2 * IN_W - FRAC_BITS;  // eta^2
  localparam int C2_W   = 22;                    // cosi^2
  localparam int T_W    = C2_W + 1;              // 1 - cosi^2
  localparam int PROD_W = E2_W + 1 + T_W;        // eta^2 * t
  localparam int K_W    = PROD_W - FRAC_BITS;    // k
  localparam int EC_W   = 21;                    // eta * cosi
  localparam int ROOT_W = 20;                    // sqrt(k * 2^F)
  localparam int COEF_W = ROOT_W + 2;            // eta*cosi + root
  localparam int CN_W   = COEF_W + IN_W;         // coef * normal component
  localparam int DIFF_W = CN_W + 1;              // eta*I - coef*N
  localparam int SH_W   = DIFF_W - FRAC_BITS;    // difference after the shift

  // Square-root unit: one result bit per stage
  localparam int RAD_W       = 2 * ROOT_W;
  localparam int REM_W       = ROOT_W + 3;
  localparam int SQRT_STAGES = ROOT_W;

  // 1.0 at the widths where it is subtracted from
  localparam logic signed [T_W-1:0] ONE_T =
    {{(T_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
  localparam logic signed [K_W-1:0] ONE_K =
    {{(K_W - FRAC_BITS - 1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

  // Output clip limits
  localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
  localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

endpackage

`default_nettype wire

// ===== rtl/vector_refract.sv =====
// Refraction of an incident vector about a surface normal, fixed point, fully pipelined.
// Depends on vr_pkg and instantiates vr_sqrt.
//
// Usage:
//   Input channel: vec_valid / vec_stall with incident_x..z, normal_x..z (signed Q1.14)
//   and index_ratio (unsigned Q2.14). A transaction completes at a rising edge with
//   vec_valid high and vec_stall low.
//   Output channel: res_valid / res_stall with refracted_x..z (signed Q5.14, clipped),
//   total_reflection and saturated; one result per input transaction, in order.
//   Pipeline: 29 register stages (6 for the dot product and k, 20 in the square-root
//   unit, 3 for the final scale, subtract and clip).
//   Throughput: one transaction per cycle while vec_stall is low, set by the square-root
//   unit retiring one root bit per stage.
//   Stall: when res_stall holds a waiting result, it moves into a skid register while
//   the pipeline still takes one more input; the pipeline then freezes and vec_stall
//   rises in the next cycle. Nothing is dropped or repeated.
//   Reset: rst (synchronous, active high) empties the pipeline and the skid register.
`default_nettype none

module vector_refract (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             vec_valid,
  output logic                             vec_stall,
  input  logic signed [vr_pkg::IN_W-1:0]   incident_x,
  input  logic signed [vr_pkg::IN_W-1:0]   incident_y,
  input  logic signed [vr_pkg::IN_W-1:0]   incident_z,
  input  logic signed [vr_pkg::IN_W-1:0]   normal_x,
  input  logic signed [vr_pkg::IN_W-1:0]   normal_y,
  input  logic signed [vr_pkg::IN_W-1:0]   normal_z,
  input  logic        [vr_pkg::IN_W-1:0]   index_ratio,
  output logic                             res_valid,
  input  logic                             res_stall,
  output logic signed [vr_pkg::OUT_W-1:0]  refracted_x,
  output logic signed [vr_pkg::OUT_W-1:0]  refracted_y,
  output logic signed [vr_pkg::OUT_W-1:0]  refracted_z,
  output logic                             total_reflection,
  output logic                             saturated
);

  typedef struct packed {
    logic signed [vr_pkg::EI_W-1:0] ei_x;
    logic signed [vr_pkg::EI_W-1:0] ei_y;
    logic signed [vr_pkg::EI_W-1:0] ei_z;
    logic signed [vr_pkg::IN_W-1:0] n_x;
    logic signed [vr_pkg::IN_W-1:0] n_y;
    logic signed [vr_pkg::IN_W-1:0] n_z;
  } carry_t;

  typedef struct packed {
    carry_t                         c;
    logic signed [vr_pkg::EC_W-1:0] ec;
    logic                           tir;
  } side_t;

  typedef struct packed {
    logic signed [vr_pkg::OUT_W-1:0] rx;
    logic signed [vr_pkg::OUT_W-1:0] ry;
    logic signed [vr_pkg::OUT_W-1:0] rz;
    logic                            tir;
    logic                            sat;
  } result_t;

  // Clip a shifted difference to the output range; top bit flags a clip
  function automatic logic [vr_pkg::OUT_W:0] clip(input logic signed [vr_pkg::SH_W-1:0] v);
    logic [vr_pkg::OUT_W:0] r;
    if (v > vr_pkg::OUT_MAX) begin
      r = {1'b1, vr_pkg::OUT_MAX};
    end else if (v < vr_pkg::OUT_MIN) begin
      r = {1'b1, vr_pkg::OUT_MIN};
    end else begin
      r = {1'b0, v[vr_pkg::OUT_W-1:0]};
    end
    return r;
  endfunction

  logic en;
  logic skid_full;

  // Stage 1: products
  logic signed [vr_pkg::IN_W:0]     eta_in;
  logic signed [2*vr_pkg::IN_W-1:0] in_px, in_py, in_pz;
  logic        [2*vr_pkg::IN_W-1:0] in_ee;
  carry_t                           in_c;
  logic                             v1;
  logic signed [2*vr_pkg::IN_W-1:0] s1_px, s1_py, s1_pz;
  logic        [2*vr_pkg::IN_W-1:0] s1_ee;
  logic        [vr_pkg::IN_W-1:0]   s1_eta;
  carry_t                           s1_c;

  assign eta_in   = signed'({1'b0, index_ratio});
  assign in_px    = incident_x * normal_x;
  assign in_py    = incident_y * normal_y;
  assign in_pz    = incident_z * normal_z;
  assign in_ee    = index_ratio * index_ratio;
  assign in_c.ei_x = eta_in * incident_x;
  assign in_c.ei_y = eta_in * incident_y;
  assign in_c.ei_z = eta_in * incident_z;
  assign in_c.n_x  = normal_x;
  assign in_c.n_y  = normal_y;
  assign in_c.n_z  = normal_z;

  always_ff @(posedge clk) begin
    if (en) begin
      s1_px  <= in_px;
      s1_py  <= in_py;
      s1_pz  <= in_pz;
      s1_ee  <= in_ee;
      s1_eta <= index_ratio;
      s1_c   <= in_c;
    end
  end

  // Stage 2: dot product, cosi and eta^2
  logic        [vr_pkg::DOT_W-1:0]  dot;
  logic                             v2;
  logic signed [vr_pkg::COSI_W-1:0] s2_cosi;
  logic        [vr_pkg::E2_W-1:0]   s2_e2;
  logic        [vr_pkg::IN_W-1:0]   s2_eta;
  carry_t                           s2_c;

  assign dot = {s1_px[2*vr_pkg::IN_W-1], s1_px} + {s1_py[2*vr_pkg::IN_W-1], s1_py}
             + {s1_pz[2*vr_pkg::IN_W-1], s1_pz};

  always_ff @(posedge clk) begin
    if (en) begin
      s2_cosi <= dot[vr_pkg::DOT_W-1:vr_pkg::FRAC_BITS];
      s2_e2   <= s1_ee[2*vr_pkg::IN_W-1:vr_pkg::FRAC_BITS];
      s2_eta  <= s1_eta;
      s2_c    <= s1_c;
    end
  end

  // Stage 3: cosi^2 and eta*cosi
  logic signed [vr_pkg::IN_W:0]                 eta2_s;
  logic signed [2*vr_pkg::COSI_W-1:0]           sq;
  logic signed [vr_pkg::IN_W+vr_pkg::COSI_W:0]  ecp;
  logic                                         v3;
  logic        [vr_pkg::C2_W-1:0]               s3_c2;
  logic        [vr_pkg::E2_W-1:0]               s3_e2;
  logic signed [vr_pkg::EC_W-1:0]               s3_ec;
  carry_t                                       s3_c;

  assign eta2_s = signed'({1'b0, s2_eta});
  assign sq     = s2_cosi * s2_cosi;
  assign ecp    = eta2_s * s2_cosi;

  always_ff @(posedge clk) begin
    if (en) begin
      s3_c2 <= sq[vr_pkg::FRAC_BITS+vr_pkg::C2_W-1:vr_pkg::FRAC_BITS];
      s3_e2 <= s2_e2;
      s3_ec <= ecp[vr_pkg::FRAC_BITS+vr_pkg::EC_W-1:vr_pkg::FRAC_BITS];
      s3_c  <= s2_c;
    end
  end

  // Stage 4: t = 1 - cosi^2
  logic                           v4;
  logic signed [vr_pkg::T_W-1:0]  s4_t;
  logic        [vr_pkg::E2_W-1:0] s4_e2;
  logic signed [vr_pkg::EC_W-1:0] s4_ec;
  carry_t                         s4_c;

  always_ff @(posedge clk) begin
    if (en) begin
      s4_t  <= vr_pkg::ONE_T - signed'({1'b0, s3_c2});
      s4_e2 <= s3_e2;
      s4_ec <= s3_ec;
      s4_c  <= s3_c;
    end
  end

  // Stage 5: eta^2 * t
  logic signed [vr_pkg::E2_W:0]     e2_s;
  logic signed [vr_pkg::PROD_W-1:0] prod;
  logic                             v5;
  logic signed [vr_pkg::PROD_W-1:0] s5_prod;
  logic signed [vr_pkg::EC_W-1:0]   s5_ec;
  carry_t                           s5_c;

  assign e2_s = signed'({1'b0, s4_e2});
  assign prod = e2_s * s4_t;

  always_ff @(posedge clk) begin
    if (en) begin
      s5_prod <= prod;
      s5_ec   <= s4_ec;
      s5_c    <= s4_c;
    end
  end

  // Stage 6: k, total internal reflection and the square-root radicand
  logic signed [vr_pkg::K_W-1:0]   k;
  logic                            v6;
  logic        [vr_pkg::RAD_W-1:0] s6_rad;
  side_t                           s6_side;

  assign k = vr_pkg::ONE_K - signed'(s5_prod[vr_pkg::PROD_W-1:vr_pkg::FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (en) begin
      if (k[vr_pkg::K_W-1]) begin
        s6_rad <= '0;
      end else begin
        s6_rad <= {k[vr_pkg::RAD_W-vr_pkg::FRAC_BITS-1:0], {vr_pkg::FRAC_BITS{1'b0}}};
      end
      s6_side.tir <= k[vr_pkg::K_W-1];
      s6_side.ec  <= s5_ec;
      s6_side.c   <= s5_c;
    end
  end

  // Stages 7 to 26: square root, with the side data delayed alongside
  logic [vr_pkg::ROOT_W-1:0]      root;
  side_t                          side_q [vr_pkg::SQRT_STAGES];
  logic [vr_pkg::SQRT_STAGES-1:0] side_v;

  vr_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .radicand (s6_rad),
    .root     (root)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_q[0] <= s6_side;
      for (int s = 1; s < vr_pkg::SQRT_STAGES; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // Stage 27: coef = eta*cosi + root
  side_t                            sq_out;
  logic                             v7;
  logic signed [vr_pkg::COEF_W-1:0] s7_coef;
  carry_t                           s7_c;
  logic                             s7_tir;

  assign sq_out = side_q[vr_pkg::SQRT_STAGES-1];

  always_ff @(posedge clk) begin
    if (en) begin
      s7_coef <= {sq_out.ec[vr_pkg::EC_W-1], sq_out.ec} + {2'b00, root};
      s7_c    <= sq_out.c;
      s7_tir  <= sq_out.tir;
    end
  end

  // Stage 28: coef * normal
  logic signed [vr_pkg::CN_W-1:0] cn_x, cn_y, cn_z;
  logic                           v8;
  logic signed [vr_pkg::CN_W-1:0] s8_cnx, s8_cny, s8_cnz;
  logic signed [vr_pkg::EI_W-1:0] s8_eix, s8_eiy, s8_eiz;
  logic                           s8_tir;

  assign cn_x = s7_coef * s7_c.n_x;
  assign cn_y = s7_coef * s7_c.n_y;
  assign cn_z = s7_coef * s7_c.n_z;

  always_ff @(posedge clk) begin
    if (en) begin
      s8_cnx <= cn_x;
      s8_cny <= cn_y;
      s8_cnz <= cn_z;
      s8_eix <= s7_c.ei_x;
      s8_eiy <= s7_c.ei_y;
      s8_eiz <= s7_c.ei_z;
      s8_tir <= s7_tir;
    end
  end

  // Stage 29: subtract, shift, clip
  logic [vr_pkg::DIFF_W-1:0] diff_x, diff_y, diff_z;
  logic [vr_pkg::OUT_W:0]    cl_x, cl_y, cl_z;
  result_t                   res_next;
  logic                      v9;
  result_t                   s9_res;

  assign diff_x = {{(vr_pkg::DIFF_W - vr_pkg::EI_W){s8_eix[vr_pkg::EI_W-1]}}, s8_eix}
                - {s8_cnx[vr_pkg::CN_W-1], s8_cnx};
  assign diff_y = {{(vr_pkg::DIFF_W - vr_pkg::EI_W){s8_eiy[vr_pkg::EI_W-1]}}, s8_eiy}
                - {s8_cny[vr_pkg::CN_W-1], s8_cny};
  assign diff_z = {{(vr_pkg::DIFF_W - vr_pkg::EI_W){s8_eiz[vr_pkg::EI_W-1]}}, s8_eiz}
                - {s8_cnz[vr_pkg::CN_W-1], s8_cnz};
  assign cl_x = clip(signed'(diff_x[vr_pkg::DIFF_W-1:vr_pkg::FRAC_BITS]));
  assign cl_y = clip(signed'(diff_y[vr_pkg::DIFF_W-1:vr_pkg::FRAC_BITS]));
  assign cl_z = clip(signed'(diff_z[vr_pkg::DIFF_W-1:vr_pkg::FRAC_BITS]));

  // Force zero on total internal reflection
  always_comb begin
    if (s8_tir) begin
      res_next.rx  = '0;
      res_next.ry  = '0;
      res_next.rz  = '0;
      res_next.tir = 1'b1;
      res_next.sat = 1'b0;
    end else begin
      res_next.rx  = cl_x[vr_pkg::OUT_W-1:0];
      res_next.ry  = cl_y[vr_pkg::OUT_W-1:0];
      res_next.rz  = cl_z[vr_pkg::OUT_W-1:0];
      res_next.tir = 1'b0;
      res_next.sat = cl_x[vr_pkg::OUT_W] | cl_y[vr_pkg::OUT_W] | cl_z[vr_pkg::OUT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_res <= res_next;
    end
  end

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      v1     <= 1'b0;
      v2     <= 1'b0;
      v3     <= 1'b0;
      v4     <= 1'b0;
      v5     <= 1'b0;
      v6     <= 1'b0;
      side_v <= '0;
      v7     <= 1'b0;
      v8     <= 1'b0;
      v9     <= 1'b0;
    end else if (en) begin
      v1     <= vec_valid;
      v2     <= v1;
      v3     <= v2;
      v4     <= v3;
      v5     <= v4;
      v6     <= v5;
      side_v <= {side_v[vr_pkg::SQRT_STAGES-2:0], v6};
      v7     <= side_v[vr_pkg::SQRT_STAGES-1];
      v8     <= v7;
      v9     <= v8;
    end
  end

  // Skid register: catch a stalled result, then freeze the pipeline
  result_t skid;

  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (!res_stall) begin
        skid_full <= 1'b0;
      end
    end else if (v9 && res_stall) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full && v9 && res_stall) begin
      skid <= s9_res;
    end
  end

  assign en        = !skid_full;
  assign vec_stall = skid_full;

  // Drive the result channel from the skid register while it holds a transaction
  assign res_valid        = skid_full | v9;
  assign refracted_x      = skid_full ? skid.rx  : s9_res.rx;
  assign refracted_y      = skid_full ? skid.ry  : s9_res.ry;
  assign refracted_z      = skid_full ? skid.rz  : s9_res.rz;
  assign total_reflection = skid_full ? skid.tir : s9_res.tir;
  assign saturated        = skid_full ? skid.sat : s9_res.sat;

endmodule

`default_nettype wire

// ===== rtl/vr_sqrt.sv =====
// Pipelined integer square root, floor(sqrt(radicand)), one result bit per stage.
// Depends on vr_pkg for widths and stage count.
`default_nettype none

module vr_sqrt (
  input  logic                       clk,
  input  logic                       en,
  input  logic [vr_pkg::RAD_W-1:0]   radicand,
  output logic [vr_pkg::ROOT_W-1:0]  root
);

  logic [vr_pkg::REM_W-1:0]  rem_q     [vr_pkg::SQRT_STAGES];
  logic [vr_pkg::ROOT_W-1:0] root_q    [vr_pkg::SQRT_STAGES];
  logic [vr_pkg::RAD_W-1:0]  rad_q     [vr_pkg::SQRT_STAGES];
  logic [vr_pkg::REM_W-1:0]  rem_next  [vr_pkg::SQRT_STAGES];
  logic [vr_pkg::ROOT_W-1:0] root_next [vr_pkg::SQRT_STAGES];
  logic [vr_pkg::RAD_W-1:0]  rad_next  [vr_pkg::SQRT_STAGES];

  // Decide one root bit per stage from the next two radicand bits
  always_comb begin
    logic [vr_pkg::REM_W-1:0]  rem_in;
    logic [vr_pkg::REM_W-1:0]  rem_sh;
    logic [vr_pkg::REM_W-1:0]  trial;
    logic [vr_pkg::ROOT_W-1:0] r_in;
    logic [vr_pkg::RAD_W-1:0]  n_in;
    for (int s = 0; s < vr_pkg::SQRT_STAGES; s++) begin
      if (s == 0) begin
        rem_in = '0;
        r_in   = '0;
        n_in   = radicand;
      end else begin
        rem_in = rem_q[s-1];
        r_in   = root_q[s-1];
        n_in   = rad_q[s-1];
      end
      rem_sh = {rem_in[vr_pkg::REM_W-3:0], n_in[vr_pkg::RAD_W-1 -: 2]};
      trial  = {{(vr_pkg::REM_W - vr_pkg::ROOT_W - 2){1'b0}}, r_in, 2'b01};
      if (rem_sh >= trial) begin
        rem_next[s]  = rem_sh - trial;
        root_next[s] = {r_in[vr_pkg::ROOT_W-2:0], 1'b1};
      end else begin
        rem_next[s]  = rem_sh;
        root_next[s] = {r_in[vr_pkg::ROOT_W-2:0], 1'b0};
      end
      rad_next[s] = {n_in[vr_pkg::RAD_W-3:0], 2'b00};
    end
  end

  // Advance all stages together
  always_ff @(posedge clk) begin
    if (en) begin
      for (int s = 0; s < vr_pkg::SQRT_STAGES; s++) begin
        rem_q[s]  <= rem_next[s];
        root_q[s] <= root_next[s];
        rad_q[s]  <= rad_next[s];
      end
    end
  end

  assign root = root_q[vr_pkg::SQRT_STAGES-1];

endmodule

`default_nettype wire
